>>> src/assert_macros.svh
// assertion macros shared by the neighbor context select rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/vp9_ncs_pkg.sv
// types, codes and reset values for the vp9 neighbor context select block
// no dependencies; used by every module of the block
package vp9_ncs_pkg;

	localparam int REF_W = 2;
	localparam int MODE_W = 3;
	localparam int CTX_W = 3;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 2;

	localparam logic [REF_W-1:0] REF_INTRA = 2'd0;
	localparam logic [REF_W-1:0] REF_LAST = 2'd1;
	localparam logic [REF_W-1:0] REF_GOLDEN = 2'd2;
	localparam logic [REF_W-1:0] REF_ALTREF = 2'd3;

	localparam logic [MODE_W-1:0] MODE_SKIP = 3'd0;
	localparam logic [MODE_W-1:0] MODE_IS_INTER = 3'd1;
	localparam logic [MODE_W-1:0] MODE_COMP_MODE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_COMP_REF = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SINGLE_REF1 = 3'd4;
	localparam logic [MODE_W-1:0] MODE_SINGLE_REF2 = 3'd5;

	localparam logic [CFG_INDEX_W-1:0] REG_FIXED_REF = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_VAR_REF_FIRST = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_VAR_REF_SECOND = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_VAR_REF_SLOT = 2'd3;

	localparam logic [REF_W-1:0] FIXED_REF_RST = REF_ALTREF;
	localparam logic [REF_W-1:0] VAR_REF_FIRST_RST = REF_LAST;
	localparam logic [REF_W-1:0] VAR_REF_SECOND_RST = REF_GOLDEN;
	localparam logic VAR_REF_SLOT_RST = 1'b0;

	typedef struct packed {
		logic [REF_W-1:0] fixed_ref;
		logic [REF_W-1:0] var_ref_first;
		logic [REF_W-1:0] var_ref_second;
		logic var_ref_slot;
	} cfg_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic above_available;
		logic left_available;
		logic [REF_W-1:0] above_ref_a;
		logic [REF_W-1:0] above_ref_b;
		logic above_compound;
		logic above_skip;
		logic [REF_W-1:0] left_ref_a;
		logic [REF_W-1:0] left_ref_b;
		logic left_compound;
		logic left_skip;
	} item_t;

	typedef struct packed {
		logic avail;
		logic intra;
		logic single;
		logic [REF_W-1:0] r0;
		logic [REF_W-1:0] r1;
		logic skip;
	} nbr_t;

endpackage

>>> src/vp9_ncs_cfg.sv
// frame-level compound reference registers of the neighbor context select
// depends on vp9_ncs_pkg
module vp9_ncs_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic write_en,
	input  logic [vp9_ncs_pkg::CFG_INDEX_W-1:0] index,
	input  logic [vp9_ncs_pkg::CFG_DATA_W-1:0] data,
	output vp9_ncs_pkg::cfg_t cfg
);

	vp9_ncs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fixed_ref <= vp9_ncs_pkg::FIXED_REF_RST;
			cfg_q.var_ref_first <= vp9_ncs_pkg::VAR_REF_FIRST_RST;
			cfg_q.var_ref_second <= vp9_ncs_pkg::VAR_REF_SECOND_RST;
			cfg_q.var_ref_slot <= vp9_ncs_pkg::VAR_REF_SLOT_RST;
		end else if (write_en) begin
			case (index)
				vp9_ncs_pkg::REG_FIXED_REF: begin
					cfg_q.fixed_ref <= data[vp9_ncs_pkg::REF_W-1:0];
				end
				vp9_ncs_pkg::REG_VAR_REF_FIRST: begin
					cfg_q.var_ref_first <= data[vp9_ncs_pkg::REF_W-1:0];
				end
				vp9_ncs_pkg::REG_VAR_REF_SECOND: begin
					cfg_q.var_ref_second <= data[vp9_ncs_pkg::REF_W-1:0];
				end
				vp9_ncs_pkg::REG_VAR_REF_SLOT: begin
					cfg_q.var_ref_slot <= data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> src/vp9_ncs_ctx.sv
// context rules for skip, is-inter, compound mode and reference elements
// depends on vp9_ncs_pkg; pure combinational logic
module vp9_ncs_ctx (
	input  vp9_ncs_pkg::item_t item,
	input  vp9_ncs_pkg::cfg_t cfg,
	output logic [vp9_ncs_pkg::CTX_W-1:0] context_index
);

	localparam logic [vp9_ncs_pkg::REF_W-1:0] LAST = vp9_ncs_pkg::REF_LAST;
	localparam logic [vp9_ncs_pkg::REF_W-1:0] GOLDEN = vp9_ncs_pkg::REF_GOLDEN;
	localparam logic [vp9_ncs_pkg::REF_W-1:0] ALTREF = vp9_ncs_pkg::REF_ALTREF;

	function automatic vp9_ncs_pkg::nbr_t make_nbr(
		input logic av,
		input logic [vp9_ncs_pkg::REF_W-1:0] ra,
		input logic [vp9_ncs_pkg::REF_W-1:0] rb,
		input logic cmp,
		input logic sk
	);
		vp9_ncs_pkg::nbr_t n;
		n.avail = av;
		n.r0 = ra;
		n.r1 = rb;
		n.intra = (ra == vp9_ncs_pkg::REF_INTRA);
		n.single = n.intra || !cmp;
		n.skip = av && sk;
		return n;
	endfunction

	function automatic logic uses(
		input vp9_ncs_pkg::nbr_t n,
		input logic [vp9_ncs_pkg::REF_W-1:0] r
	);
		return (n.r0 == r) || (n.r1 == r);
	endfunction

	function automatic logic [vp9_ncs_pkg::REF_W-1:0] var_of(
		input vp9_ncs_pkg::nbr_t n,
		input logic slot
	);
		logic [vp9_ncs_pkg::REF_W-1:0] r;
		if (n.single) begin
			r = n.r0;
		end else begin
			r = slot ? n.r1 : n.r0;
		end
		return r;
	endfunction

	function automatic logic [2:0] is_inter_ctx(
		input vp9_ncs_pkg::nbr_t a,
		input vp9_ncs_pkg::nbr_t l
	);
		logic [2:0] c;
		if (a.avail && l.avail) begin
			c = (a.intra && l.intra) ? 3'd3 : {2'b00, a.intra || l.intra};
		end else if (a.avail) begin
			c = {1'b0, a.intra, 1'b0};
		end else if (l.avail) begin
			c = {1'b0, l.intra, 1'b0};
		end else begin
			c = 3'd0;
		end
		return c;
	endfunction

	function automatic logic [2:0] comp_mode_ctx(
		input vp9_ncs_pkg::nbr_t a,
		input vp9_ncs_pkg::nbr_t l,
		input vp9_ncs_pkg::cfg_t k
	);
		logic af;
		logic lf;
		logic [2:0] c;
		af = (a.r0 == k.fixed_ref);
		lf = (l.r0 == k.fixed_ref);
		if (a.avail && l.avail) begin
			if (a.single && l.single) begin
				c = {2'b00, af ^ lf};
			end else if (a.single) begin
				c = 3'd2 + {2'b00, af || a.intra};
			end else if (l.single) begin
				c = 3'd2 + {2'b00, lf || l.intra};
			end else begin
				c = 3'd4;
			end
		end else if (a.avail) begin
			c = a.single ? {2'b00, af} : 3'd3;
		end else if (l.avail) begin
			c = l.single ? {2'b00, lf} : 3'd3;
		end else begin
			c = 3'd1;
		end
		return c;
	endfunction

	function automatic logic [2:0] comp_ref_one(
		input vp9_ncs_pkg::nbr_t n,
		input vp9_ncs_pkg::cfg_t k
	);
		logic [2:0] c;
		if (n.intra) begin
			c = 3'd2;
		end else if (n.single) begin
			c = (n.r0 != k.var_ref_second) ? 3'd3 : 3'd0;
		end else begin
			c = (var_of(n, k.var_ref_slot) != k.var_ref_second) ? 3'd4 : 3'd0;
		end
		return c;
	endfunction

	function automatic logic [2:0] comp_ref_ctx(
		input vp9_ncs_pkg::nbr_t a,
		input vp9_ncs_pkg::nbr_t l,
		input vp9_ncs_pkg::cfg_t k
	);
		logic [vp9_ncs_pkg::REF_W-1:0] va;
		logic [vp9_ncs_pkg::REF_W-1:0] vl;
		logic [vp9_ncs_pkg::REF_W-1:0] vc;
		logic [vp9_ncs_pkg::REF_W-1:0] rs;
		logic [2:0] c;
		va = var_of(a, k.var_ref_slot);
		vl = var_of(l, k.var_ref_slot);
		vc = l.single ? va : vl;
		rs = a.single ? va : vl;
		if (a.avail && l.avail) begin
			if (a.intra && l.intra) begin
				c = 3'd2;
			end else if (l.intra) begin
				c = (va != k.var_ref_second) ? 3'd3 : 3'd1;
			end else if (a.intra) begin
				c = (vl != k.var_ref_second) ? 3'd3 : 3'd1;
			end else if (va == vl && va == k.var_ref_second) begin
				c = 3'd0;
			end else if (a.single && l.single) begin
				if ((va == k.fixed_ref && vl == k.var_ref_first) ||
					(vl == k.fixed_ref && va == k.var_ref_first)) begin
					c = 3'd4;
				end else begin
					c = (va == vl) ? 3'd3 : 3'd1;
				end
			end else if (a.single || l.single) begin
				if (vc == k.var_ref_second && rs != k.var_ref_second) begin
					c = 3'd1;
				end else if (rs == k.var_ref_second && vc != k.var_ref_second) begin
					c = 3'd2;
				end else begin
					c = 3'd4;
				end
			end else begin
				c = (va == vl) ? 3'd4 : 3'd2;
			end
		end else if (a.avail) begin
			c = comp_ref_one(a, k);
		end else if (l.avail) begin
			c = comp_ref_one(l, k);
		end else begin
			c = 3'd2;
		end
		return c;
	endfunction

	function automatic logic [2:0] sr1_one(input vp9_ncs_pkg::nbr_t n);
		logic [2:0] c;
		if (n.intra) begin
			c = 3'd2;
		end else if (n.single) begin
			c = (n.r0 == LAST) ? 3'd4 : 3'd0;
		end else begin
			c = 3'd1 + {2'b00, uses(n, LAST)};
		end
		return c;
	endfunction

	function automatic logic [2:0] single1_ctx(
		input vp9_ncs_pkg::nbr_t a,
		input vp9_ncs_pkg::nbr_t l
	);
		vp9_ncs_pkg::nbr_t s;
		vp9_ncs_pkg::nbr_t m;
		logic [2:0] c;
		s = a.single ? a : l;
		m = a.single ? l : a;
		if (a.avail && l.avail) begin
			if (a.intra && l.intra) begin
				c = 3'd2;
			end else if (l.intra) begin
				c = sr1_one(a);
			end else if (a.intra) begin
				c = sr1_one(l);
			end else if (a.single && l.single) begin
				c = {1'b0, a.r0 == LAST, 1'b0} + {1'b0, l.r0 == LAST, 1'b0};
			end else if (!a.single && !l.single) begin
				c = 3'd1 + {2'b00, uses(a, LAST) || uses(l, LAST)};
			end else begin
				c = {2'b00, uses(m, LAST)} + ((s.r0 == LAST) ? 3'd3 : 3'd0);
			end
		end else if (a.avail) begin
			c = sr1_one(a);
		end else if (l.avail) begin
			c = sr1_one(l);
		end else begin
			c = 3'd2;
		end
		return c;
	endfunction

	function automatic logic [2:0] sr2_pair_one(input vp9_ncs_pkg::nbr_t n);
		logic [2:0] c;
		if (n.single) begin
			if (n.r0 == LAST) begin
				c = 3'd3;
			end else begin
				c = (n.r0 == GOLDEN) ? 3'd4 : 3'd0;
			end
		end else begin
			c = uses(n, GOLDEN) ? 3'd3 : 3'd1;
		end
		return c;
	endfunction

	function automatic logic [2:0] sr2_lone(input vp9_ncs_pkg::nbr_t n);
		logic [2:0] c;
		if (n.intra || (n.single && n.r0 == LAST)) begin
			c = 3'd2;
		end else if (n.single) begin
			c = (n.r0 == GOLDEN) ? 3'd4 : 3'd0;
		end else begin
			c = uses(n, GOLDEN) ? 3'd3 : 3'd0;
		end
		return c;
	endfunction

	function automatic logic [2:0] single2_ctx(
		input vp9_ncs_pkg::nbr_t a,
		input vp9_ncs_pkg::nbr_t l
	);
		vp9_ncs_pkg::nbr_t s;
		vp9_ncs_pkg::nbr_t m;
		logic al;
		logic ll;
		logic u;
		logic [2:0] c;
		s = a.single ? a : l;
		m = a.single ? l : a;
		al = (a.r0 == LAST);
		ll = (l.r0 == LAST);
		u = uses(m, GOLDEN);
		if (a.avail && l.avail) begin
			if (a.intra && l.intra) begin
				c = 3'd2;
			end else if (l.intra) begin
				c = sr2_pair_one(a);
			end else if (a.intra) begin
				c = sr2_pair_one(l);
			end else if (a.single && l.single) begin
				if (al && ll) begin
					c = 3'd3;
				end else if (al) begin
					c = (l.r0 == GOLDEN) ? 3'd4 : 3'd0;
				end else if (ll) begin
					c = (a.r0 == GOLDEN) ? 3'd4 : 3'd0;
				end else begin
					c = {1'b0, a.r0 == GOLDEN, 1'b0} + {1'b0, l.r0 == GOLDEN, 1'b0};
				end
			end else if (!a.single && !l.single) begin
				if (a.r0 == l.r0 && a.r1 == l.r1) begin
					c = uses(a, GOLDEN) ? 3'd3 : 3'd0;
				end else begin
					c = 3'd2;
				end
			end else begin
				if (s.r0 == GOLDEN) begin
					c = {2'b00, u} + 3'd3;
				end else if (s.r0 != ALTREF) begin
					c = u ? 3'd3 : 3'd1;
				end else begin
					c = {2'b00, u};
				end
			end
		end else if (a.avail) begin
			c = sr2_lone(a);
		end else if (l.avail) begin
			c = sr2_lone(l);
		end else begin
			c = 3'd2;
		end
		return c;
	endfunction

	vp9_ncs_pkg::nbr_t above;
	vp9_ncs_pkg::nbr_t left;

	assign above = make_nbr(item.above_available, item.above_ref_a, item.above_ref_b,
		item.above_compound, item.above_skip);
	assign left = make_nbr(item.left_available, item.left_ref_a, item.left_ref_b,
		item.left_compound, item.left_skip);

	always_comb begin
		case (item.mode)
			vp9_ncs_pkg::MODE_SKIP: begin
				context_index = {2'b00, above.skip} + {2'b00, left.skip};
			end
			vp9_ncs_pkg::MODE_IS_INTER: begin
				context_index = is_inter_ctx(above, left);
			end
			vp9_ncs_pkg::MODE_COMP_MODE: begin
				context_index = comp_mode_ctx(above, left, cfg);
			end
			vp9_ncs_pkg::MODE_COMP_REF: begin
				context_index = comp_ref_ctx(above, left, cfg);
			end
			vp9_ncs_pkg::MODE_SINGLE_REF1: begin
				context_index = single1_ctx(above, left);
			end
			vp9_ncs_pkg::MODE_SINGLE_REF2: begin
				context_index = single2_ctx(above, left);
			end
			default: begin
				context_index = '0;
			end
		endcase
	end

endmodule

>>> src/vp9_neighbor_context_select.sv
// top level of the vp9 neighbor context select: input and result registers
// depends on vp9_ncs_pkg, vp9_ncs_cfg, vp9_ncs_ctx and assert_macros.svh
//
// usage
// - input channel in_valid/in_ready carries one beat per syntax element:
//   the element code in mode plus the above and left neighbor descriptions
// - output channel out_valid/out_ready returns one beat with context_index
//   for every input beat, in order
// - cfg_write_en/cfg_index/cfg_data write the frame-level compound
//   references; write them only while no beat is in flight
// - order: a taken beat is registered in the input register, its context is
//   then registered in the result register, from which it can be taken
// - throughput: one beat per cycle unless out_ready stalls; the context rules are a
//   single level of logic between the input register and the result register
// - the result register and the input register each hold one beat, so a
//   new beat is still taken while a finished result waits for out_ready
// - when out_ready stays low both registers fill and in_ready drops
// - reset empties both registers and loads fixed_ref altref, var_ref_first
//   last, var_ref_second golden and var_ref_slot 0
`include "assert_macros.svh"

module vp9_neighbor_context_select (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [vp9_ncs_pkg::MODE_W-1:0] mode,
	input  logic above_available,
	input  logic left_available,
	input  logic [vp9_ncs_pkg::REF_W-1:0] above_ref_a,
	input  logic [vp9_ncs_pkg::REF_W-1:0] above_ref_b,
	input  logic above_compound,
	input  logic above_skip,
	input  logic [vp9_ncs_pkg::REF_W-1:0] left_ref_a,
	input  logic [vp9_ncs_pkg::REF_W-1:0] left_ref_b,
	input  logic left_compound,
	input  logic left_skip,
	output logic out_valid,
	input  logic out_ready,
	output logic [vp9_ncs_pkg::CTX_W-1:0] context_index,
	input  logic cfg_write_en,
	input  logic [vp9_ncs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [vp9_ncs_pkg::CFG_DATA_W-1:0] cfg_data
);

	vp9_ncs_pkg::cfg_t cfg;
	vp9_ncs_pkg::item_t item_in;
	vp9_ncs_pkg::item_t item_s1;
	logic valid_s1;
	logic valid_s2;
	logic load_s2;
	logic [vp9_ncs_pkg::CTX_W-1:0] ctx_comb;
	logic [vp9_ncs_pkg::CTX_W-1:0] ctx_s2;

	vp9_ncs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.write_en (cfg_write_en),
		.index    (cfg_index),
		.data     (cfg_data),
		.cfg      (cfg)
	);

	assign item_in.mode = mode;
	assign item_in.above_available = above_available;
	assign item_in.left_available = left_available;
	assign item_in.above_ref_a = above_ref_a;
	assign item_in.above_ref_b = above_ref_b;
	assign item_in.above_compound = above_compound;
	assign item_in.above_skip = above_skip;
	assign item_in.left_ref_a = left_ref_a;
	assign item_in.left_ref_b = left_ref_b;
	assign item_in.left_compound = left_compound;
	assign item_in.left_skip = left_skip;

	assign load_s2 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_in;
		end
	end

	vp9_ncs_ctx u_ctx (
		.item          (item_s1),
		.cfg           (cfg),
		.context_index (ctx_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			ctx_s2 <= ctx_comb;
		end
	end

	assign out_valid = valid_s2;
	assign context_index = ctx_s2;

	`ASSERT_NEXT(a_take_fills_s1, clk, arst_n, in_valid && in_ready, valid_s1)
	`ASSERT_NEXT(a_blocked_s1_holds, clk, arst_n, valid_s1 && !load_s2, valid_s1 && $stable(item_s1))
	`ASSERT_NEXT(a_unused_mode_zero, clk, arst_n, valid_s1 && load_s2 && item_s1.mode > vp9_ncs_pkg::MODE_SINGLE_REF2, context_index == '0)
	`ASSERT_NEXT(a_skip_no_nbr, clk, arst_n, valid_s1 && load_s2 && item_s1.mode == vp9_ncs_pkg::MODE_SKIP && !item_s1.above_available && !item_s1.left_available, context_index == '0)
	`ASSERT_IMPLY(a_ctx_range, clk, arst_n, valid_s2, context_index <= 3'd4)

endmodule
